/* design/dwa_pkg.sv */
// dwa_pkg: shared constants for the delayed window average block.
// No dependencies; imported by delayed_window_average_top and its testbench.
`default_nettype none

package dwa_pkg;

   // default geometry of the delay line and sample width
   localparam int WindowStartDef = 10;
   localparam int WindowLenDef   = 25;
   localparam int SampleBitsDef  = 16;

endpackage : dwa_pkg

`default_nettype wire

/* design/delayed_window_average_top.sv */
// delayed_window_average_top: delayed boxcar moving average, top level.
// Depends on dwa_pkg for parameter defaults.
`default_nettype none

// One signed sample per request; one average per request, in order. A delay
// line of WINDOW_START + WINDOW_LEN samples is kept in flip-flops. A nonzero
// sample shifts in and the response is the mean of the entries at delays
// WINDOW_START .. WINDOW_START + WINDOW_LEN - 1, truncated toward zero. The
// first nonzero sample after an empty line fills the whole line with itself.
// A zero sample empties the line and the previous mean is returned again.
// Throughput is one request per clock while rsp_stall is low. A request
// lands in the input register on the accepting edge, the running sum is
// updated as it moves on into the sum stage, and the divide-by-length (a
// reciprocal multiply) loads the response register, which drives rsp_valid,
// as it moves on again. Under rsp_stall the pipe holds three requests before
// req_stall rises. The running sum is updated incrementally (entry entering
// the window minus entry leaving it), so no stage ever adds more than a
// couple of terms. After reset the line is empty and the held mean is zero.

module delayed_window_average_top
   import dwa_pkg::*;
#(
   parameter int WINDOW_START = WindowStartDef,
   parameter int WINDOW_LEN   = WindowLenDef,
   parameter int SAMPLE_BITS  = SampleBitsDef
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_average
);

   // ------------------------------------------------------------------
   // derived geometry
   // ------------------------------------------------------------------
   localparam int LineDepth = WINDOW_START + WINDOW_LEN;
   localparam int LenBits   = $clog2(WINDOW_LEN);
   // window sum holds WINDOW_LEN full-scale samples
   localparam int SumBits   = SAMPLE_BITS + LenBits;
   // entry that moves into the window on a shift (the new sample itself
   // when the window starts at delay zero)
   localparam int EnterIdx  = (WINDOW_START == 0) ? 0 : WINDOW_START - 1;
   // exact floor division of a SumBits-wide magnitude by WINDOW_LEN:
   // q = (mag * ceil(2^DivShift / L)) >> DivShift
   localparam int DivShift  = SumBits + LenBits;
   localparam int RecipBits = SumBits + 1;
   localparam int ProdBits  = SumBits + RecipBits;
   localparam logic [RecipBits-1:0] Recip =
      RecipBits'(((64'd1 << DivShift) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
   localparam logic signed [SumBits-1:0] WinLenS = SumBits'(WINDOW_LEN);

   // ------------------------------------------------------------------
   // pipeline handshake
   // ------------------------------------------------------------------
   logic                          in_vld_ff,  in_vld_in;
   logic signed [SAMPLE_BITS-1:0] in_sample_ff;
   logic                          mid_vld_ff, mid_vld_in;
   logic                          mid_hold_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_average_ff, rsp_average_in;

   logic out_free;   // response register can take a new request
   logic mid_move;   // sum stage hands its request to the response register
   logic mid_free;
   logic in_move;    // input register hands its request to the sum stage
   logic in_free;
   logic req_take;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign mid_move = mid_vld_ff && out_free;
   assign mid_free = !mid_vld_ff || out_free;
   assign in_move  = in_vld_ff && mid_free;
   assign in_free  = !in_vld_ff || mid_free;
   assign req_take = req_valid && in_free;

   assign req_stall   = !in_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (in_move) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      mid_vld_in = mid_vld_ff;
      if (in_move) begin
         mid_vld_in = 1'b1;
      end else if (mid_move) begin
         mid_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (mid_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         mid_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_vld_ff    <= in_vld_in;
         mid_vld_ff   <= mid_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_sample;
      end
      if (in_move) begin
         mid_hold_ff <= (in_sample_ff == '0);
      end
   end

   // ------------------------------------------------------------------
   // delay line and running window sum (updated as a request leaves the
   // input register)
   // ------------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] line_ff [LineDepth];
   logic signed [SAMPLE_BITS-1:0] line_in [LineDepth];
   logic signed [SumBits-1:0]     window_sum_ff, window_sum_in;
   logic                          line_filled_ff, line_filled_in;
   logic                          samp_zero;
   logic signed [SAMPLE_BITS-1:0] enter_val;
   logic signed [SAMPLE_BITS-1:0] leave_val;

   assign samp_zero = (in_sample_ff == '0);
   assign enter_val = (WINDOW_START == 0) ? in_sample_ff : line_ff[EnterIdx];
   assign leave_val = line_ff[LineDepth-1];

   always_comb begin
      for (int i = 0; i < LineDepth; i++) begin
         if (samp_zero) begin
            line_in[i] = '0;
         end else if (!line_filled_ff || i == 0) begin
            line_in[i] = in_sample_ff;
         end else begin
            line_in[i] = line_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   always_comb begin
      if (samp_zero) begin
         window_sum_in  = '0;
         line_filled_in = 1'b0;
      end else if (!line_filled_ff) begin
         // fill: every window entry equals the sample
         window_sum_in  = SumBits'(SumBits'(in_sample_ff) * WinLenS);
         line_filled_in = 1'b1;
      end else begin
         window_sum_in  = window_sum_ff + SumBits'(enter_val) - SumBits'(leave_val);
         line_filled_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         for (int i = 0; i < LineDepth; i++) begin
            line_ff[i] <= line_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_sum_ff  <= '0;
         line_filled_ff <= 1'b0;
      end else if (in_move) begin
         window_sum_ff  <= window_sum_in;
         line_filled_ff <= line_filled_in;
      end
   end

   // ------------------------------------------------------------------
   // divide by window length, truncating toward zero
   // window_sum_ff belongs to the request in the sum stage: a newer request
   // can only update it on the same edge that this one moves out.
   // ------------------------------------------------------------------
   logic                          sum_neg;
   logic [SumBits-1:0]            sum_mag;
   logic [ProdBits-1:0]           div_prod;
   logic [SAMPLE_BITS-1:0]        quot_mag;
   logic signed [SAMPLE_BITS-1:0] mean_val;

   assign sum_neg  = window_sum_ff[SumBits-1];
   assign sum_mag  = sum_neg ? SumBits'(-window_sum_ff) : SumBits'(window_sum_ff);
   assign div_prod = ProdBits'(sum_mag) * ProdBits'(Recip);
   assign quot_mag = div_prod[DivShift +: SAMPLE_BITS];
   assign mean_val = sum_neg ? SAMPLE_BITS'(-quot_mag) : SAMPLE_BITS'(quot_mag);

   // a zero sample returns the last mean again, so the register just holds
   assign rsp_average_in = mid_hold_ff ? rsp_average_ff : mean_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_average_ff <= '0;
      end else if (mid_move) begin
         rsp_average_ff <= rsp_average_in;
      end
   end

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // an empty line always carries a zero running sum
   a_empty_sum_zero : assert property (@(posedge clock) disable iff (reset)
      !line_filled_ff |-> (window_sum_ff == '0))
      else $error("window sum nonzero while line is empty");

   // a filled line always holds a nonzero newest entry
   a_filled_head_nonzero : assert property (@(posedge clock) disable iff (reset)
      line_filled_ff |-> (line_ff[0] != '0))
      else $error("filled line has a zero newest entry");

   // a zero-sample request repeats the previous mean
   a_hold_repeats : assert property (@(posedge clock) disable iff (reset)
      (mid_move && mid_hold_ff) |=> (rsp_average_ff == $past(rsp_average_ff)))
      else $error("held mean changed on a zero sample");

endmodule : delayed_window_average_top

`default_nettype wire

/* tb/sv/tb_delayed_window_average_top.sv */
// Self-checking testbench for delayed_window_average_top: drives signed samples,
// predicts each delayed-window mean in place and compares every response in order.
// Depends on dwa_pkg and the delayed_window_average_top RTL.
`timescale 1ns / 1ps

module tb_delayed_window_average_top
   import dwa_pkg::*;
();

   localparam int LineDepth  = WindowStartDef + WindowLenDef;
   localparam int CycleLimit = 200000;   // far above the slowest legal run
   localparam int DrainWait  = 10;       // three-stage pipe plus margin

   typedef logic signed [SampleBitsDef-1:0] sample_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   sample_type req_sample = '0;
   logic       rsp_stall = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   sample_type rsp_average;

   delayed_window_average_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_average (rsp_average)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: our own copy of the delay line, fill flag and the
   // mean that a zero sample hands back again.
   // ---------------------------------------------------------------------
   sample_type history [LineDepth];
   bit         history_filled = 1'b0;
   sample_type last_mean      = '0;

   sample_type expected_averages [$];   // one entry per accepted request
   int      error_count   = 0;
   int      cycle_count   = 0;
   bit      idle_en       = 1'b1;    // random gaps on both sides
   int      stall_hold_req = 0;      // long receiver hold, handed to the receiver
   int      hold_left     = 0;
   int      burst_left    = 0;

   initial begin
      for (int i = 0; i < LineDepth; i++) history[i] = '0;
   end

   // Advance the predictor by one sample and return the mean it should emit.
   function automatic sample_type predict_average(input sample_type s);
      int window_total;
      window_total = 0;
      if (s != 0) begin
         if (history_filled) begin
            for (int i = LineDepth - 1; i > 0; i--) history[i] = history[i-1];
            history[0] = s;
         end else begin
            // first nonzero sample after an empty line fills every slot
            for (int i = 0; i < LineDepth; i++) history[i] = s;
            history_filled = 1'b1;
         end
         for (int i = WindowStartDef; i < LineDepth; i++) window_total += history[i];
         // SV integer division truncates toward zero, as the block must
         last_mean = sample_type'(window_total / WindowLenDef);
      end else begin
         // zero sample empties the line; the old mean is repeated
         for (int i = 0; i < LineDepth; i++) history[i] = '0;
         history_filled = 1'b0;
      end
      return last_mean;
   endfunction

   // Nonzero sample of a random flavor: full range, small, rail, or raw bits.
   function automatic sample_type nonzero_sample(input int kind);
      sample_type v;
      case (kind)
         0: begin
            v = sample_type'($urandom_range(0, 65535));
         end
         1: begin
            v = sample_type'(int'($urandom_range(0, 100)) - 50);
         end
         2: begin
            v = $urandom_range(0, 1) ? sample_type'(32767) : sample_type'(-32768);
         end
         default: begin
            v = sample_type'($urandom());
         end
      endcase
      if (v == 0) v = sample_type'(1);
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: one request per call. Optional gap first, then hold the
   // payload steady until an edge sees valid high and stall low.
   // ---------------------------------------------------------------------
   task automatic send_request(input sample_type s);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_averages.push_back(predict_average(s));
   endtask

   // ---------------------------------------------------------------------
   // Receiver: checks each accepted response against the oldest
   // expectation, then decides the stall for the next cycle. Short random
   // bursts while idle_en is set; a long hold when a test asks for one.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_averages.size() == 0) begin
            $error("average: response %0d with no request outstanding", rsp_average);
            error_count++;
         end else begin
            want = expected_averages.pop_front();
            if (rsp_average !== want) begin
               $error("average: expected %0d, got %0d", want, rsp_average);
               error_count++;
            end
         end
      end

      if (stall_hold_req > 0) begin
         hold_left      = stall_hold_req;
         stall_hold_req = 0;
      end
      if (burst_left == 0 && idle_en && $urandom_range(0, 3) == 0)
         burst_left = $urandom_range(1, 3);

      rsp_stall <= (hold_left > 0) || (burst_left > 0);
      if (hold_left > 0) hold_left--;
      if (burst_left > 0) burst_left--;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Zero right after reset returns the reset mean; fill, rails, clear, refill.
   task automatic test_special_cases();
      send_request(sample_type'(0));        // empty line, held mean is zero
      send_request(sample_type'(32767));    // empty line: fill with max
      send_request(sample_type'(-32768));   // shifts in, window still all max
      send_request(sample_type'(-1));
      send_request(sample_type'(0));        // clear, mean repeated
      send_request(sample_type'(0));        // second clear in a row
      send_request(sample_type'(-32768));   // refill with min
      send_request(sample_type'(16'h5555));
      send_request(sample_type'(16'hAAAA));
      send_request(sample_type'(0));
      send_request(sample_type'(-1));       // fill with -1: mean must be -1
      send_request(sample_type'(1));
   endtask

   // Fill with one value, then push a different one until it reaches the
   // first delay inside the window; the mean only moves on the eleventh.
   task automatic test_window_delay();
      send_request(sample_type'(0));
      send_request(sample_type'(-7));
      for (int i = 0; i < WindowStartDef + 1; i++) send_request(sample_type'(32000));
   endtask

   // Mostly nonzero runs with random content, ended by a zero now and then;
   // the rest are noise items that may hit zero anywhere.
   task automatic test_random_runs(input int n_items);
      int sent;
      int run_len;
      int kind;
      sent = 0;
      while (sent < n_items) begin
         idle_en = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) != 0) begin
            run_len = $urandom_range(1, 80);
            kind    = $urandom_range(0, 3);
            for (int i = 0; i < run_len; i++) begin
               // mix flavors inside some runs
               if ($urandom_range(0, 7) == 0) kind = $urandom_range(0, 3);
               send_request(nonzero_sample(kind));
            end
            sent += run_len;
            if ($urandom_range(0, 2) == 0) begin
               send_request(sample_type'(0));
               sent++;
            end
         end else begin
            run_len = $urandom_range(1, 12);
            for (int i = 0; i < run_len; i++) begin
               if ($urandom_range(0, 3) == 0) send_request(sample_type'(0));
               else send_request(sample_type'($urandom_range(0, 65535)));
            end
            sent += run_len;
         end
      end
      idle_en = 1'b1;
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so
   // the pipe fills and req_stall has to rise.
   task automatic test_backpressure();
      stall_hold_req = 60;
      for (int i = 0; i < 40; i++) send_request(nonzero_sample($urandom_range(0, 3)));
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_full_rate();
      idle_en = 1'b0;
      for (int i = 0; i < 100; i++) begin
         if ($urandom_range(0, 29) == 0) send_request(sample_type'(0));
         else send_request(nonzero_sample($urandom_range(0, 3)));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_cases();
      test_window_delay();
      test_random_runs(940);
      test_backpressure();
      test_full_rate();
      req_valid <= 1'b0;

      // drain: everything out, then let the pipe settle
      while (expected_averages.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
